@@ hdl/dmx_pkg.sv @@
package dmx_pkg;

    localparam int SLOT_COUNT_DEFAULT = 512;
    localparam int CHANNELS_DEFAULT   = 3;

    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W  = 10;

    localparam logic [CFG_INDEX_W-1:0] REG_DEV_ADDRESS   = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_BLINK_TICKS   = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_NO_DATA_TICKS = 2'd2;

    localparam logic [9:0] DEV_ADDRESS_RESET   = 10'd1;
    localparam logic [7:0] BLINK_TICKS_RESET   = 8'd250;
    localparam logic [9:0] NO_DATA_TICKS_RESET = 10'd1000;

    localparam logic [7:0] POLL_CODE = 8'hF0;

    typedef struct packed {
        logic       mode;
        logic [7:0] rx_byte;
        logic       frame_error;
    } in_word_t;

    typedef struct packed {
        logic [7:0] chan_a_duty;
        logic [7:0] chan_b_duty;
        logic [7:0] chan_c_duty;
        logic       link_led;
        logic       reply_led;
        logic       send_break;
    } out_word_t;

    typedef struct packed {
        logic                   we;
        logic [CFG_INDEX_W-1:0] index;
        logic [CFG_DATA_W-1:0]  data;
    } cfg_write_t;

    typedef struct packed {
        logic      valid;
        out_word_t word;
    } push_t;

endpackage

@@ hdl/dmx_stream_if.sv @@
interface dmx_stream_if #(
    parameter type payload_t = logic [7:0]
);
    logic     valid;
    logic     ready;
    payload_t payload;

    modport source (output valid, output payload, input ready);
    modport sink (input valid, input payload, output ready);
endinterface

@@ hdl/dmx_parser.sv @@
module dmx_parser
    import dmx_pkg::*;
#(
    parameter int SLOT_COUNT = SLOT_COUNT_DEFAULT,
    parameter int CHANNELS   = CHANNELS_DEFAULT
) (
    input  logic         clk,
    input  logic         rst_n,
    input  cfg_write_t   cfg,
    dmx_stream_if.sink   in_ch,
    input  logic         buf_full,
    output push_t        push
);

    localparam int CW = $clog2(CHANNELS + 1);

    localparam logic [1:0] PH_IDLE  = 2'd0;
    localparam logic [1:0] PH_START = 2'd1;
    localparam logic [1:0] PH_DATA  = 2'd2;
    localparam logic [1:0] PH_POLL  = 2'd3;

    logic [9:0]    dev_address_reg;
    logic [7:0]    blink_ticks_reg;
    logic [9:0]    no_data_ticks_reg;

    logic [1:0]    phase_reg, phase_next;
    logic [9:0]    slot_reg, slot_next;
    logic [CW-1:0] cap_reg, cap_next;
    logic [CW-1:0] cap_inc;
    logic [7:0]    chan_reg [CHANNELS];
    logic [7:0]    chan_next [CHANNELS];
    logic [7:0]    poll_reg, poll_next;
    logic [7:0]    pv_new;
    logic [7:0]    blink_reg, blink_next;
    logic [7:0]    reply_left_reg, reply_left_next;
    logic [9:0]    nodata_reg, nodata_next;
    logic          link_reg, link_next;
    logic          reply_on_reg, reply_on_next;
    logic          brk;
    logic          accept;
    logic [7:0]    shown [3];
    in_word_t      w;

    assign in_ch.ready = !buf_full;
    assign accept      = in_ch.valid && !buf_full;
    assign w           = in_ch.payload;
    assign cap_inc     = cap_reg + CW'(1);
    assign pv_new      = (slot_reg == dev_address_reg) ? w.rx_byte : poll_reg;

    // config registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dev_address_reg   <= DEV_ADDRESS_RESET;
            blink_ticks_reg   <= BLINK_TICKS_RESET;
            no_data_ticks_reg <= NO_DATA_TICKS_RESET;
        end
        else if (cfg.we)
        begin
            if (cfg.index == REG_DEV_ADDRESS)
                dev_address_reg <= cfg.data;
            if (cfg.index == REG_BLINK_TICKS)
                blink_ticks_reg <= cfg.data[7:0];
            if (cfg.index == REG_NO_DATA_TICKS)
                no_data_ticks_reg <= cfg.data;
        end
    end

    always_comb
    begin
        phase_next      = phase_reg;
        slot_next       = slot_reg;
        cap_next        = cap_reg;
        chan_next       = chan_reg;
        poll_next       = poll_reg;
        blink_next      = blink_reg;
        reply_left_next = reply_left_reg;
        nodata_next     = nodata_reg;
        link_next       = link_reg;
        reply_on_next   = reply_on_reg;
        brk             = 1'b0;
        if (accept)
        begin
            if (w.mode)
            begin
                // timers in fixed order: blink, reply, no-data
                if (blink_reg != 8'd0)
                begin
                    blink_next = blink_reg - 8'd1;
                    if (blink_reg == 8'd1)
                        link_next = 1'b1;
                end
                if (reply_left_reg != 8'd0)
                begin
                    reply_left_next = reply_left_reg - 8'd1;
                    if (reply_left_reg == 8'd1)
                        reply_on_next = 1'b0;
                end
                if (nodata_reg != 10'd0)
                begin
                    nodata_next = nodata_reg - 10'd1;
                    if (nodata_reg == 10'd1)
                        link_next = 1'b0;
                end
            end
            else if (w.frame_error)
            begin
                if (w.rx_byte == 8'd0)
                begin
                    phase_next = PH_START;
                    cap_next   = '0;
                end
            end
            else
            begin
                unique case (phase_reg)
                    PH_IDLE:
                    begin
                    end
                    PH_START:
                    begin
                        if (w.rx_byte == 8'd0)
                        begin
                            phase_next  = PH_DATA;
                            slot_next   = 10'd1;
                            cap_next    = '0;
                            nodata_next = no_data_ticks_reg;
                            if (blink_reg == 8'd0)
                                link_next = 1'b1;
                        end
                        else if (w.rx_byte == POLL_CODE)
                        begin
                            phase_next = PH_POLL;
                            slot_next  = 10'd1;
                            poll_next  = 8'd0;
                        end
                        else
                        begin
                            phase_next = PH_IDLE;
                            cap_next   = '0;
                        end
                    end
                    PH_DATA:
                    begin
                        if (cap_reg != '0 || slot_reg == dev_address_reg)
                        begin
                            for (int k = 0; k < CHANNELS; k++)
                            begin
                                if (cap_reg == CW'(k) && chan_reg[k] != w.rx_byte)
                                begin
                                    chan_next[k] = w.rx_byte;
                                    blink_next   = blink_ticks_reg;
                                    link_next    = 1'b0;
                                end
                            end
                            if (cap_inc >= CW'(CHANNELS))
                            begin
                                phase_next = PH_IDLE;
                                cap_next   = '0;
                            end
                            else
                            begin
                                cap_next = cap_inc;
                            end
                        end
                        else if (slot_reg >= 10'(SLOT_COUNT))
                        begin
                            phase_next = PH_IDLE;
                            cap_next   = '0;
                        end
                        else
                        begin
                            slot_next = slot_reg + 10'd1;
                        end
                    end
                    PH_POLL:
                    begin
                        poll_next = pv_new;
                        if (slot_reg >= 10'(SLOT_COUNT))
                        begin
                            phase_next = PH_IDLE;
                            cap_next   = '0;
                            if (pv_new != 8'd0)
                            begin
                                reply_left_next = blink_ticks_reg;
                                reply_on_next   = 1'b1;
                                brk             = 1'b1;
                            end
                        end
                        else
                        begin
                            slot_next = slot_reg + 10'd1;
                        end
                    end
                endcase
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg      <= PH_IDLE;
            slot_reg       <= 10'd0;
            cap_reg        <= '0;
            poll_reg       <= 8'd0;
            blink_reg      <= 8'd0;
            reply_left_reg <= 8'd0;
            nodata_reg     <= 10'd0;
            link_reg       <= 1'b0;
            reply_on_reg   <= 1'b0;
            for (int k = 0; k < CHANNELS; k++)
                chan_reg[k] <= 8'd0;
        end
        else
        begin
            phase_reg      <= phase_next;
            slot_reg       <= slot_next;
            cap_reg        <= cap_next;
            poll_reg       <= poll_next;
            blink_reg      <= blink_next;
            reply_left_reg <= reply_left_next;
            nodata_reg     <= nodata_next;
            link_reg       <= link_next;
            reply_on_reg   <= reply_on_next;
            chan_reg       <= chan_next;
        end
    end

    // channels past the third are kept but not shown
    always_comb
    begin
        for (int j = 0; j < 3; j++)
            shown[j] = 8'd0;
        for (int k = 0; k < CHANNELS; k++)
            if (k < 3)
                shown[k] = chan_next[k];
    end

    always_comb
    begin
        push.valid            = accept;
        push.word.chan_a_duty = shown[0];
        push.word.chan_b_duty = shown[1];
        push.word.chan_c_duty = shown[2];
        push.word.link_led    = link_next;
        push.word.reply_led   = reply_on_next;
        push.word.send_break  = brk;
    end

endmodule

@@ hdl/dmx_out_buf.sv @@
module dmx_out_buf
    import dmx_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  push_t        push,
    output logic         full,
    dmx_stream_if.source out_ch
);

    out_word_t  mem_reg [2];
    logic       wr_ptr_reg, rd_ptr_reg;
    logic [1:0] count_reg, count_next;
    logic       do_push, do_pop;

    assign full           = (count_reg == 2'd2);
    assign do_push        = push.valid && !full;
    assign do_pop         = out_ch.valid && out_ch.ready;
    assign out_ch.valid   = (count_reg != 2'd0);
    assign out_ch.payload = mem_reg[rd_ptr_reg];

    always_comb
    begin
        count_next = count_reg;
        if (do_push && !do_pop)
            count_next = count_reg + 2'd1;
        else if (!do_push && do_pop)
            count_next = count_reg - 2'd1;
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
            mem_reg[wr_ptr_reg] <= push.word;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            if (do_push)
                wr_ptr_reg <= !wr_ptr_reg;
            if (do_pop)
                rd_ptr_reg <= !rd_ptr_reg;
            count_reg <= count_next;
        end
    end

endmodule

@@ hdl/dmx512_slot_receiver_top.sv @@
// channel   dir  payload                                            handshake
// in_ch     in   mode, rx_byte, frame_error                         valid/ready
// out_ch    out  chan_a/b/c_duty, link_led, reply_led, send_break   valid/ready
// cfg       in   cfg_index, cfg_data                                cfg_we
//
// one word in, one word out; a word is taken every cycle while the
// two-entry output buffer has room, and its result is ready the next cycle
// all control state resets asynchronously on rst_n low; duties and leds
// reset to zero, registers to their defaults
// a stalled output holds up input only after two results are waiting
module dmx512_slot_receiver_top
    import dmx_pkg::*;
#(
    parameter int SLOT_COUNT = SLOT_COUNT_DEFAULT,
    parameter int CHANNELS   = CHANNELS_DEFAULT
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   cfg_we,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data,
    dmx_stream_if.sink             in_ch,
    dmx_stream_if.source           out_ch
);

    cfg_write_t cfg;
    push_t      push;
    logic       buf_full;

    assign cfg.we    = cfg_we;
    assign cfg.index = cfg_index;
    assign cfg.data  = cfg_data;

    dmx_parser #(
        .SLOT_COUNT (SLOT_COUNT),
        .CHANNELS   (CHANNELS)
    ) u_parser (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg      (cfg),
        .in_ch    (in_ch),
        .buf_full (buf_full),
        .push     (push)
    );

    dmx_out_buf u_out_buf (
        .clk    (clk),
        .rst_n  (rst_n),
        .push   (push),
        .full   (buf_full),
        .out_ch (out_ch)
    );

    // a break reply always lights the reply led
    a_break_lights_led: assert property (@(posedge clk) disable iff (!rst_n)
        out_ch.valid |-> !(out_ch.payload.send_break && !out_ch.payload.reply_led))
        else $error("send_break without reply_led");

    // input stalls only while results wait
    a_stall_needs_backlog: assert property (@(posedge clk) disable iff (!rst_n)
        !in_ch.ready |-> out_ch.valid)
        else $error("input stalled with empty output");

    // an accepted word yields a result next cycle
    a_accept_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
        (in_ch.valid && in_ch.ready) |=> out_ch.valid)
        else $error("accepted word produced no result");

endmodule

@@ tb/dmx512_slot_receiver_top_test.sv @@
`timescale 1ns / 1ps

module dmx512_slot_receiver_top_test;
    import dmx_pkg::*;

    localparam int QUIET_LIMIT = 2000;
    localparam int HOLD_CYCLES = 300;
    localparam int SLOTS = SLOT_COUNT_DEFAULT;
    localparam int CHANS = CHANNELS_DEFAULT;

    typedef enum logic [1:0] {PH_IDLE, PH_START, PH_DATA, PH_POLL} rx_phase_e;

    logic                   clk;
    logic                   rst_n;
    logic                   cfg_we;
    logic [CFG_INDEX_W-1:0] cfg_index;
    logic [CFG_DATA_W-1:0]  cfg_data;

    dmx_stream_if #(.payload_t(in_word_t))  in_ch ();
    dmx_stream_if #(.payload_t(out_word_t)) out_ch ();

    dmx512_slot_receiver_top uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_ch     (in_ch),
        .out_ch    (out_ch)
    );

    // register copies
    logic [9:0] cfg_addr   = DEV_ADDRESS_RESET;
    logic [7:0] cfg_blink  = BLINK_TICKS_RESET;
    logic [9:0] cfg_nodata = NO_DATA_TICKS_RESET;

    // receiver state
    rx_phase_e  rx_phase  = PH_IDLE;
    int         slot_no   = 0;
    int         grab_idx  = 0;
    logic [7:0] duty [CHANS] = '{default: 8'h00};
    logic [7:0] poll_byte = 8'h00;
    int         blink_cnt = 0;
    int         reply_cnt = 0;
    int         quiet_cnt = 0;
    logic       link_lvl  = 1'b0;
    logic       reply_lvl = 1'b0;

    in_word_t  rx_words [$];
    out_word_t awaited_outputs [$];

    int   words_queued  = 0;
    int   words_taken   = 0;
    int   mismatches    = 0;
    int   replies_seen  = 0;
    int   settings_used = 0;
    int   gap_pct       = 0;
    int   stall_pct     = 0;
    int   hold_count    = 0;
    int   quiet_cycles  = 0;
    logic hold_on       = 1'b0;
    logic in_fire       = 1'b0;
    logic [7:0] fill_byte = 8'h5A;

    function automatic out_word_t decode_word(input in_word_t w);
        out_word_t r;
        logic      pulse;
        pulse = 1'b0;
        if (w.mode)
        begin
            // blink, then reply, then no-data timer
            if (blink_cnt != 0)
            begin
                blink_cnt--;
                if (blink_cnt == 0)
                    link_lvl = 1'b1;
            end
            if (reply_cnt != 0)
            begin
                reply_cnt--;
                if (reply_cnt == 0)
                    reply_lvl = 1'b0;
            end
            if (quiet_cnt != 0)
            begin
                quiet_cnt--;
                if (quiet_cnt == 0)
                    link_lvl = 1'b0;
            end
        end
        else if (w.frame_error)
        begin
            if (w.rx_byte == 8'h00)
            begin
                rx_phase = PH_START;
                grab_idx = 0;
            end
        end
        else
        begin
            case (rx_phase)
                PH_START:
                begin
                    if (w.rx_byte == 8'h00)
                    begin
                        rx_phase  = PH_DATA;
                        slot_no   = 1;
                        grab_idx  = 0;
                        quiet_cnt = cfg_nodata;
                        if (blink_cnt == 0)
                            link_lvl = 1'b1;
                    end
                    else if (w.rx_byte == POLL_CODE)
                    begin
                        rx_phase  = PH_POLL;
                        slot_no   = 1;
                        poll_byte = 8'h00;
                    end
                    else
                    begin
                        rx_phase = PH_IDLE;
                        grab_idx = 0;
                    end
                end
                PH_DATA:
                begin
                    if (grab_idx > 0 || slot_no == cfg_addr)
                    begin
                        if (grab_idx < CHANS && duty[grab_idx] != w.rx_byte)
                        begin
                            duty[grab_idx] = w.rx_byte;
                            blink_cnt      = cfg_blink;
                            link_lvl       = 1'b0;
                        end
                        grab_idx++;
                        if (grab_idx >= CHANS)
                        begin
                            rx_phase = PH_IDLE;
                            grab_idx = 0;
                        end
                    end
                    else if (slot_no >= SLOTS)
                    begin
                        rx_phase = PH_IDLE;
                        grab_idx = 0;
                    end
                    else
                        slot_no++;
                end
                PH_POLL:
                begin
                    if (slot_no == cfg_addr)
                        poll_byte = w.rx_byte;
                    if (slot_no >= SLOTS)
                    begin
                        rx_phase = PH_IDLE;
                        grab_idx = 0;
                        if (poll_byte != 8'h00)
                        begin
                            reply_cnt = cfg_blink;
                            reply_lvl = 1'b1;
                            pulse     = 1'b1;
                        end
                    end
                    else
                        slot_no++;
                end
                default: ;
            endcase
        end
        r.chan_a_duty = duty[0];
        r.chan_b_duty = duty[1];
        r.chan_c_duty = duty[2];
        r.link_led    = link_lvl;
        r.reply_led   = reply_lvl;
        r.send_break  = pulse;
        return r;
    endfunction

    function automatic void check_field(input string field, input logic [7:0] want,
                                        input logic [7:0] got);
        if (want !== got)
        begin
            $error("%s: expected %0d, got %0d", field, want, got);
            mismatches++;
        end
    endfunction

    initial
    begin
        clk = 1'b0;
    end

    always #4 clk = ~clk;

    // driver
    always @(negedge clk)
    begin
        if (!rst_n)
            in_ch.valid <= 1'b0;
        else if (!in_ch.valid || in_fire)
        begin
            if (rx_words.size() != 0 && $urandom_range(99) >= gap_pct)
            begin
                in_ch.valid   <= 1'b1;
                in_ch.payload <= rx_words.pop_front();
            end
            else
                in_ch.valid <= 1'b0;
        end
    end

    // receiver side, with one long hold-off
    always @(negedge clk)
    begin
        if (!rst_n)
            out_ch.ready <= 1'b0;
        else if (hold_on && hold_count < HOLD_CYCLES)
        begin
            out_ch.ready <= 1'b0;
            hold_count   <= hold_count + 1;
        end
        else
            out_ch.ready <= ($urandom_range(99) >= stall_pct);
    end

    // monitor
    always @(posedge clk)
    begin : monitor
        out_word_t want;
        out_word_t got;
        if (!rst_n)
            in_fire <= 1'b0;
        else
        begin
            in_fire <= in_ch.valid && in_ch.ready;
            if (in_ch.valid && in_ch.ready)
            begin
                awaited_outputs.push_back(decode_word(in_ch.payload));
                words_taken++;
            end
            if (out_ch.valid && out_ch.ready)
            begin
                got = out_ch.payload;
                if (awaited_outputs.size() == 0)
                begin
                    $error("output word with nothing pending");
                    mismatches++;
                end
                else
                begin
                    want = awaited_outputs.pop_front();
                    if (want.send_break)
                        replies_seen++;
                    check_field("chan_a_duty", want.chan_a_duty, got.chan_a_duty);
                    check_field("chan_b_duty", want.chan_b_duty, got.chan_b_duty);
                    check_field("chan_c_duty", want.chan_c_duty, got.chan_c_duty);
                    check_field("link_led", want.link_led, got.link_led);
                    check_field("reply_led", want.reply_led, got.reply_led);
                    check_field("send_break", want.send_break, got.send_break);
                end
            end
        end
    end

    // watchdog
    always @(posedge clk)
    begin
        if (!rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
            quiet_cycles <= 0;
        else if (quiet_cycles >= QUIET_LIMIT)
        begin
            $display("end of test: mismatches");
            $finish;
        end
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    task automatic push_byte(input logic [7:0] b, input logic fe);
        in_word_t w;
        w.mode        = 1'b0;
        w.rx_byte     = b;
        w.frame_error = fe;
        rx_words.push_back(w);
        words_queued++;
    endtask

    task automatic push_tick();
        in_word_t w;
        w.mode        = 1'b1;
        w.rx_byte     = 8'($urandom);
        w.frame_error = 1'($urandom);
        rx_words.push_back(w);
        words_queued++;
    endtask

    function automatic logic [7:0] slot_byte();
        int pick;
        pick = $urandom_range(7);
        if (pick < 3)
            return fill_byte;
        else if (pick == 3)
            return 8'h00;
        else if (pick == 4)
            return 8'hFF;
        return 8'($urandom);
    endfunction

    // break, start code, then len slots; at_dev < 0 means random at the address
    task automatic add_frame(input logic [7:0] code, input int len, input int at_dev);
        int s;
        push_byte(8'h00, 1'b1);
        push_byte(code, 1'b0);
        for (s = 1; s <= len; s++)
        begin
            if ($urandom_range(19) == 0)
                push_tick();
            if ($urandom_range(29) == 0)
                push_byte(8'($urandom_range(1, 255)), 1'b1);
            if (s == cfg_addr && at_dev >= 0)
                push_byte(8'(at_dev), 1'b0);
            else
                push_byte(slot_byte(), 1'b0);
        end
    endtask

    task automatic add_random_traffic(input int budget);
        int  first;
        int  pick;
        int  n;
        logic reachable;
        first     = words_queued;
        reachable = (cfg_addr >= 1 && cfg_addr <= SLOTS);
        while (words_queued - first < budget)
        begin
            pick = $urandom_range(99);
            if (pick < 40)
                add_frame(8'h00, reachable ? cfg_addr + 2 + $urandom_range(0, 3)
                                           : $urandom_range(1, 20), -1);
            else if (pick < 50)
                add_frame(8'h00, reachable ? cfg_addr + $urandom_range(0, 1)
                                           : $urandom_range(1, 5), -1);
            else if (pick < 58)
                add_frame(POLL_CODE, $urandom_range(1, 20), -1);
            else if (pick < 64)
                add_frame(8'($urandom_range(1, 255)), $urandom_range(0, 4), -1);
            else if (pick < 82)
            begin
                n = ($urandom_range(9) == 0) ? $urandom_range(50, 300) : $urandom_range(1, 8);
                repeat (n) push_tick();
            end
            else
                push_byte(8'($urandom), 1'($urandom));
        end
    endtask

    task automatic wait_drained();
        while (words_taken != words_queued || awaited_outputs.size() != 0)
            @(negedge clk);
    endtask

    task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx, input int value);
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value[CFG_DATA_W-1:0];
        @(negedge clk);
        cfg_we <= 1'b0;
        case (idx)
            REG_DEV_ADDRESS:   cfg_addr   = value[9:0];
            REG_BLINK_TICKS:   cfg_blink  = value[7:0];
            REG_NO_DATA_TICKS: cfg_nodata = value[9:0];
            default: ;
        endcase
    endtask

    task automatic set_registers(input int addr, input int blink, input int nodata);
        write_reg(REG_DEV_ADDRESS, addr);
        write_reg(REG_BLINK_TICKS, blink);
        write_reg(REG_NO_DATA_TICKS, nodata);
        settings_used++;
    endtask

    task automatic run_phase(input int addr, input int blink, input int nodata,
                             input int gap, input int stall, input int budget,
                             input int poll_at_dev);
        wait_drained();
        repeat (4) @(negedge clk);
        set_registers(addr, blink, nodata);
        gap_pct   = gap;
        stall_pct = stall;
        fill_byte = 8'($urandom);
        if (poll_at_dev >= 0)
            add_frame(POLL_CODE, SLOTS, poll_at_dev);
        add_random_traffic(budget);
    endtask

    initial
    begin
        rst_n         = 1'b0;
        cfg_we        = 1'b0;
        cfg_index     = REG_DEV_ADDRESS;
        cfg_data      = '0;
        in_ch.valid   = 1'b0;
        in_ch.payload = '0;
        out_ch.ready  = 1'b0;
        repeat (3) @(negedge clk);
        rst_n <= 1'b1;

        set_registers(2, 2, 3);
        // directed: idle bytes, unknown start, abandoned poll and capture, blink and timeouts
        push_tick();
        push_byte(8'hFF, 1'b1);
        push_byte(8'h33, 1'b0);
        push_byte(8'h00, 1'b1);
        push_byte(8'h7E, 1'b0);
        push_byte(8'h00, 1'b1);
        push_byte(POLL_CODE, 1'b0);
        push_byte(8'h10, 1'b0);
        push_byte(8'h99, 1'b0);
        push_byte(8'h00, 1'b1);
        push_byte(8'h00, 1'b0);
        push_byte(8'h00, 1'b0);
        push_byte(8'h80, 1'b1);
        push_byte(8'hFF, 1'b0);
        push_byte(8'h01, 1'b0);
        push_byte(8'h00, 1'b1);
        push_byte(8'h00, 1'b0);
        push_byte(8'h44, 1'b0);
        push_byte(8'hFF, 1'b0);
        push_byte(8'h00, 1'b0);
        push_byte(8'h80, 1'b0);
        repeat (4) push_tick();

        run_phase(1, 4, 30, 0, 0, 20, -1);
        hold_on = 1'b1;
        run_phase(9, 255, 1023, 47, 0, 20, -1);
        run_phase(7, 1, 1, 0, 47, 20, -1);
        run_phase(3, 0, 12, 8, 8, 20, -1);
        run_phase(0, 2, 0, 0, 0, 20, -1);
        run_phase(1023, 9, 5, 47, 0, 20, -1);
        run_phase(512, 6, 40, 0, 47, 0, $urandom_range(1, 255));
        run_phase(20, 3, 8, 8, 8, 20, -1);

        wait_drained();
        repeat (20) @(negedge clk);
        $display("covered %0d words over %0d register settings, %0d poll replies",
                 words_taken, settings_used, replies_seen);
        if (mismatches == 0 && awaited_outputs.size() == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule
